// File: src/lzw_code_decoder_unit_defines.svh
`ifndef LZW_CODE_DECODER_UNIT_DEFINES_SVH
`define LZW_CODE_DECODER_UNIT_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define LZWD_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define LZWD_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lzwd_pkg.sv
`timescale 1ns / 1ps
package lzwd_pkg;

    localparam int CODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // First code that names a dictionary entry; everything below is a literal.
    localparam logic [CODE_W-1:0] LITERALS = 12'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_TAIL,
        S_ADD,
        S_EMIT
    } lzwd_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
        logic [LEN_W-1:0]  len;
    } dict_word_t;

    typedef struct packed {
        logic             start;
        logic             bad;
        logic [LEN_W-1:0] len;
    } emit_cmd_t;

endpackage

// File: src/lzwd_dict_ram.sv
`timescale 1ns / 1ps
module lzwd_dict_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  lzwd_pkg::dict_word_t       wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output lzwd_pkg::dict_word_t       rdata
);

    lzwd_pkg::dict_word_t mem [DEPTH];
    lzwd_pkg::dict_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data is held until the next read so that the walker can use it.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lzwd_emit.sv
`timescale 1ns / 1ps
module lzwd_emit #(
    parameter int DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           stk_we,
    input  logic [$clog2(DEPTH)-1:0]       stk_addr,
    input  logic [lzwd_pkg::BYTE_W-1:0]    stk_wdata,
    input  lzwd_pkg::emit_cmd_t            cmd,
    output logic                           busy,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           last_byte,
    output logic                           bad_code
);

    localparam int AW = $clog2(DEPTH);

    logic [lzwd_pkg::BYTE_W-1:0] stack [DEPTH];
    logic [lzwd_pkg::BYTE_W-1:0] q_reg;

    logic                        active_reg, active_next;
    logic                        pend_reg, pend_next;
    logic [lzwd_pkg::LEN_W-1:0]  k_reg, k_next;
    logic [lzwd_pkg::LEN_W-1:0]  rd_idx_reg;
    logic [lzwd_pkg::LEN_W-1:0]  len_reg;
    logic                        bad_reg;
    logic                        out_valid_reg;
    logic [lzwd_pkg::BYTE_W-1:0] data_byte_reg;
    logic                        last_byte_reg;
    logic                        bad_code_reg;

    logic load;
    logic issue;

    // The output register takes the fetched byte when it is empty or being emptied.
    assign load  = pend_reg && (!out_valid_reg || out_ready);
    assign issue = active_reg && (k_reg != len_reg) && (!pend_reg || load);

    always_comb
    begin
        active_next = active_reg;
        k_next      = k_reg;
        pend_next   = issue || (pend_reg && !load);
        if (issue)
        begin
            k_next = k_reg + 1'b1;
        end
        if (active_reg && (k_reg == len_reg) && !pend_reg)
        begin
            active_next = 1'b0;
        end
        if (cmd.start)
        begin
            active_next = 1'b1;
            k_next      = '0;
            pend_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack[stk_addr] <= stk_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            q_reg      <= stack[AW'(k_reg)];
            rd_idx_reg <= k_reg;
        end
        if (cmd.start)
        begin
            len_reg <= cmd.len;
            bad_reg <= cmd.bad;
        end
        if (load)
        begin
            data_byte_reg <= bad_reg ? '0 : q_reg;
            last_byte_reg <= (rd_idx_reg == (len_reg - 1'b1));
            bad_code_reg  <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            k_reg      <= k_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign busy      = active_reg;
    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign last_byte = last_byte_reg;
    assign bad_code  = bad_code_reg;

endmodule

// File: src/lzw_code_decoder_unit.sv
// LZW code decoder: one 12-bit code per input beat, one decoded byte per output beat.
// A dictionary code is unwound by reading its prefix chain from the dictionary, then its
// bytes are read out in order; a code equal to the next free code is unwound from the
// previous code. A new code is taken only once the bytes of the last have left the stack.
// Reset (rst_n, asynchronous, active low) closes the stream and sets the next free code to 256.
`timescale 1ns / 1ps
`include "lzw_code_decoder_unit_defines.svh"
module lzw_code_decoder_unit #(
    parameter int DICT_ENTRIES = 4096,
    parameter int MAX_STRING   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lzwd_pkg::CODE_W-1:0]    code,
    input  logic                           start_of_stream,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           last_byte,
    output logic                           bad_code
);

    localparam int IDX_W  = $clog2(DICT_ENTRIES);
    localparam int NFC_W  = $clog2(DICT_ENTRIES + 1);
    localparam int CMP_W  = (NFC_W > lzwd_pkg::CODE_W) ? NFC_W : lzwd_pkg::CODE_W;
    localparam int STK_AW = $clog2(MAX_STRING);
    localparam int LEN_W  = lzwd_pkg::LEN_W;
    localparam int BYTE_W = lzwd_pkg::BYTE_W;
    localparam int CODE_W = lzwd_pkg::CODE_W;

    // Decoder state held across codes.
    lzwd_pkg::lzwd_state_t      state_reg, state_next;
    logic [NFC_W-1:0]           nfc_reg, nfc_next;
    logic [CODE_W-1:0]          prev_code_reg, prev_code_next;
    logic [BYTE_W-1:0]          pfb_reg, pfb_next;
    logic [LEN_W-1:0]           prev_len_reg, prev_len_next;
    logic                       open_reg, open_next;

    // Per-code working registers.
    logic [CODE_W-1:0]          code_reg;
    logic                       sos_reg;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [BYTE_W-1:0]          first_reg, first_next;
    logic [BYTE_W-1:0]          tail_reg, tail_next;
    logic [LEN_W-1:0]           pos_reg, pos_next;
    logic                       walk_first_reg, walk_first_next;
    logic                       kwk_reg, kwk_next;
    logic                       can_add_reg, can_add_next;

    // Dictionary port.
    logic                       dict_we;
    logic [IDX_W-1:0]           dict_waddr;
    lzwd_pkg::dict_word_t       dict_wdata;
    logic                       dict_re;
    logic [IDX_W-1:0]           dict_raddr;
    lzwd_pkg::dict_word_t       rd_word;

    // Unwind stack write port and read-out control.
    logic                       stk_we;
    logic [STK_AW-1:0]          stk_addr;
    logic [BYTE_W-1:0]          stk_wdata;
    lzwd_pkg::emit_cmd_t        emit_cmd;
    logic                       emit_busy;

    logic                       is_start;
    logic                       code_lit;
    logic                       code_defined;
    logic                       code_kwk;
    logic                       can_add;
    logic [LEN_W-1:0]           pos_eff;
    logic [LEN_W-1:0]           pos_dec;
    logic                       walk_more;

    assign in_ready = (state_reg == lzwd_pkg::S_IDLE);

    // The dictionary holds prefix code, suffix byte and string length in one word.
    // Reads and the one write that a code may make fall in different states, so an entry is
    // never read in the cycle in which it is written.
    lzwd_dict_ram #(
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .clk   (clk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (dict_wdata),
        .re    (dict_re),
        .raddr (dict_raddr),
        .rdata (rd_word)
    );

    // The string is unwound last byte first into the stack, then read out in order.
    lzwd_emit #(
        .DEPTH (MAX_STRING)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .stk_we    (stk_we),
        .stk_addr  (stk_addr),
        .stk_wdata (stk_wdata),
        .cmd       (emit_cmd),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .bad_code  (bad_code)
    );

    always_comb
    begin
        state_next      = state_reg;
        nfc_next        = nfc_reg;
        prev_code_next  = prev_code_reg;
        pfb_next        = pfb_reg;
        prev_len_next   = prev_len_reg;
        open_next       = open_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        tail_next       = tail_reg;
        pos_next        = pos_reg;
        walk_first_next = walk_first_reg;
        kwk_next        = kwk_reg;
        can_add_next    = can_add_reg;

        dict_we    = 1'b0;
        dict_waddr = IDX_W'(nfc_reg);
        dict_wdata = '0;
        dict_re    = 1'b0;
        dict_raddr = IDX_W'(code_reg);
        stk_we     = 1'b0;
        stk_addr   = '0;
        stk_wdata  = '0;
        emit_cmd   = '0;

        // A code with no stream open is treated as the first code of a new stream.
        is_start     = sos_reg || !open_reg;
        code_lit     = (code_reg < lzwd_pkg::LITERALS);
        can_add      = (nfc_reg < NFC_W'(DICT_ENTRIES))
                       && (prev_len_reg < LEN_W'(MAX_STRING));
        code_defined = code_lit || (CMP_W'(code_reg) < CMP_W'(nfc_reg));
        // The code about to be defined is legal only if its entry may be added.
        code_kwk     = (CMP_W'(code_reg) == CMP_W'(nfc_reg)) && can_add;

        // On the first read of a walk the remaining length comes from the entry itself.
        pos_eff   = walk_first_reg ? rd_word.len : pos_reg;
        pos_dec   = pos_eff - 1'b1;
        walk_more = (pos_dec > LEN_W'(1)) && (rd_word.prefix >= lzwd_pkg::LITERALS);

        case (state_reg)
            lzwd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lzwd_pkg::S_DECIDE;
                end
            end

            lzwd_pkg::S_DECIDE:
            begin
                if (is_start)
                begin
                    // A refused first code leaves the stream exactly as it was.
                    if (code_lit)
                    begin
                        nfc_next       = NFC_W'(lzwd_pkg::LITERALS);
                        prev_code_next = code_reg;
                        pfb_next       = code_reg[BYTE_W-1:0];
                        prev_len_next  = LEN_W'(1);
                        open_next      = 1'b1;
                        stk_we         = 1'b1;
                        stk_wdata      = code_reg[BYTE_W-1:0];
                    end
                    emit_cmd.start = 1'b1;
                    emit_cmd.bad   = !code_lit;
                    emit_cmd.len   = LEN_W'(1);
                    state_next     = lzwd_pkg::S_EMIT;
                end
                else if (code_lit)
                begin
                    stk_we       = 1'b1;
                    stk_wdata    = code_reg[BYTE_W-1:0];
                    first_next   = code_reg[BYTE_W-1:0];
                    len_next     = LEN_W'(1);
                    can_add_next = can_add;
                    state_next   = lzwd_pkg::S_ADD;
                end
                else if (code_defined)
                begin
                    dict_re         = 1'b1;
                    dict_raddr      = IDX_W'(code_reg);
                    walk_first_next = 1'b1;
                    kwk_next        = 1'b0;
                    can_add_next    = can_add;
                    state_next      = lzwd_pkg::S_WALK;
                end
                else if (code_kwk)
                begin
                    // Previous string followed by its own first byte: place that byte
                    // at the end, then unwind the previous code in front of it.
                    stk_we       = 1'b1;
                    stk_addr     = STK_AW'(prev_len_reg);
                    stk_wdata    = pfb_reg;
                    len_next     = LEN_W'(prev_len_reg + 1'b1);
                    can_add_next = can_add;
                    if (prev_code_reg < lzwd_pkg::LITERALS)
                    begin
                        tail_next  = prev_code_reg[BYTE_W-1:0];
                        state_next = lzwd_pkg::S_TAIL;
                    end
                    else
                    begin
                        dict_re         = 1'b1;
                        dict_raddr      = IDX_W'(prev_code_reg);
                        walk_first_next = 1'b1;
                        kwk_next        = 1'b1;
                        state_next      = lzwd_pkg::S_WALK;
                    end
                end
                else
                begin
                    emit_cmd.start = 1'b1;
                    emit_cmd.bad   = 1'b1;
                    emit_cmd.len   = LEN_W'(1);
                    state_next     = lzwd_pkg::S_EMIT;
                end
            end

            lzwd_pkg::S_WALK:
            begin
                // One link of the prefix chain per cycle: store the suffix and
                // follow the prefix straight from the read data.
                stk_we          = 1'b1;
                stk_addr        = STK_AW'(pos_dec);
                stk_wdata       = rd_word.suffix;
                pos_next        = pos_dec;
                walk_first_next = 1'b0;
                if (walk_first_reg && !kwk_reg)
                begin
                    len_next = rd_word.len;
                end
                if (walk_more)
                begin
                    dict_re    = 1'b1;
                    dict_raddr = IDX_W'(rd_word.prefix);
                end
                else
                begin
                    tail_next  = rd_word.prefix[BYTE_W-1:0];
                    state_next = lzwd_pkg::S_TAIL;
                end
            end

            lzwd_pkg::S_TAIL:
            begin
                stk_we     = 1'b1;
                stk_wdata  = tail_reg;
                first_next = tail_reg;
                state_next = lzwd_pkg::S_ADD;
            end

            lzwd_pkg::S_ADD:
            begin
                if (can_add_reg)
                begin
                    dict_we           = 1'b1;
                    dict_waddr        = IDX_W'(nfc_reg);
                    dict_wdata.prefix = prev_code_reg;
                    dict_wdata.suffix = first_reg;
                    dict_wdata.len    = LEN_W'(prev_len_reg + 1'b1);
                    nfc_next          = NFC_W'(nfc_reg + 1'b1);
                end
                prev_code_next = code_reg;
                pfb_next       = first_reg;
                prev_len_next  = len_reg;
                emit_cmd.start = 1'b1;
                emit_cmd.len   = len_reg;
                state_next     = lzwd_pkg::S_EMIT;
            end

            lzwd_pkg::S_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = lzwd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lzwd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwd_pkg::S_IDLE;
            nfc_reg       <= NFC_W'(lzwd_pkg::LITERALS);
            prev_code_reg <= '0;
            pfb_reg       <= '0;
            prev_len_reg  <= LEN_W'(1);
            open_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nfc_reg       <= nfc_next;
            prev_code_reg <= prev_code_next;
            pfb_reg       <= pfb_next;
            prev_len_reg  <= prev_len_next;
            open_reg      <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= code;
            sos_reg  <= start_of_stream;
        end
        len_reg        <= len_next;
        first_reg      <= first_next;
        tail_reg       <= tail_next;
        pos_reg        <= pos_next;
        walk_first_reg <= walk_first_next;
        kwk_reg        <= kwk_next;
        can_add_reg    <= can_add_next;
    end

    // An added entry always advances the next free code by exactly one.
    `LZWD_ASSERT_NEXT(a_add_advances, clk, rst_n, dict_we, nfc_reg == $past(nfc_reg) + 1'b1, "next free code did not advance after an add")
    // The dictionary is never read and written in the same cycle.
    `LZWD_ASSERT_NOW(a_dict_interlock, clk, rst_n, dict_we, !dict_re, "dictionary read and write overlap")
    // A new code is taken only once the previous string has been handed to the output.
    `LZWD_ASSERT_NOW(a_accept_idle, clk, rst_n, in_valid && in_ready, !emit_busy, "code accepted while bytes remain unread")
    // A refused code gives a single beat that is also the last one.
    `LZWD_ASSERT_NOW(a_bad_single, clk, rst_n, out_valid && bad_code, last_byte && (data_byte == '0), "bad-code beat is not a lone zero byte")

endmodule

// File: tb/lzw_code_decoder_unit_test.sv
`timescale 1ns / 1ps
module lzw_code_decoder_unit_test;

    localparam int CODE_W         = lzwd_pkg::CODE_W;
    localparam int BYTE_W         = lzwd_pkg::BYTE_W;
    localparam logic [CODE_W-1:0] LITERALS = lzwd_pkg::LITERALS;
    localparam int DICT_DEPTH     = 4096;
    localparam int MAX_STR        = 64;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 150;
    localparam longint TIMEOUT_CYCLES = 1_500_000;

    // One expected output beat: a decoded byte with its flags.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              bad;
    } decoded_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CODE_W-1:0] code = '0;
    logic              start_of_stream = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              bad_code;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    // Mirror of the decoder's dictionary and stream state.
    logic [CODE_W-1:0] dict_prefix [0:DICT_DEPTH-1];
    logic [BYTE_W-1:0] dict_suffix [0:DICT_DEPTH-1];
    logic [6:0]        dict_len    [0:DICT_DEPTH-1];
    int unsigned       free_code = 256;
    logic [CODE_W-1:0] last_code = '0;
    logic [BYTE_W-1:0] last_first = '0;
    bit                stream_live = 1'b0;
    logic [BYTE_W-1:0] spelled [0:MAX_STR-1];

    decoded_beat_t expected_bytes [$];

    lzw_code_decoder_unit #(
        .DICT_ENTRIES (DICT_DEPTH),
        .MAX_STRING   (MAX_STR)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .code            (code),
        .start_of_stream (start_of_stream),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .bad_code        (bad_code)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // The receiver stalls at random; with a zero percentage it is always ready.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Length of the string named by a code; literals are one byte long.
    function automatic int unsigned string_length(input int unsigned c);
        if (c < LITERALS)
            return 1;
        return dict_len[c];
    endfunction

    // Walks the prefix chain of a defined code backwards, filling the spelled
    // buffer from its last byte towards its first. Returns the string length.
    function automatic int unsigned spell_code(input int unsigned c);
        int unsigned n;
        int unsigned pos;
        int unsigned walk;
        n = string_length(c);
        if (n == 0)
            n = 1;
        if (n > MAX_STR)
            n = MAX_STR;
        pos = n;
        walk = c;
        while (pos > 1 && walk >= LITERALS)
        begin
            pos--;
            spelled[pos] = dict_suffix[walk];
            walk = dict_prefix[walk];
        end
        spelled[0] = walk[BYTE_W-1:0];
        return n;
    endfunction

    function automatic void push_refusal();
        decoded_beat_t b;
        b.data = '0;
        b.last = 1'b1;
        b.bad  = 1'b1;
        expected_bytes = {expected_bytes, b};
    endfunction

    // Works out the output beats that one accepted code causes and updates the
    // mirrored dictionary in the same way the decoder must.
    function automatic void predict_decode(input logic [CODE_W-1:0] c, input logic sos);
        int unsigned n;
        int unsigned prev_n;
        bit room;
        decoded_beat_t b;
        if (sos || !stream_live)
        begin
            // Opening code: only a literal may start a stream. A refused one
            // leaves the dictionary and the open/closed state alone.
            if (c >= LITERALS)
            begin
                push_refusal();
                return;
            end
            free_code   = LITERALS;
            last_code   = c;
            last_first  = c[BYTE_W-1:0];
            stream_live = 1'b1;
            b.data = c[BYTE_W-1:0];
            b.last = 1'b1;
            b.bad  = 1'b0;
            expected_bytes = {expected_bytes, b};
            return;
        end

        prev_n = string_length(last_code);
        room   = (free_code < DICT_DEPTH) && (prev_n + 1 <= MAX_STR);

        if (c < LITERALS || c < free_code)
        begin
            n = spell_code(c);
        end
        else if (c == free_code && room)
        begin
            // The code names the entry about to be made: previous string plus
            // its own first byte.
            n = spell_code(last_code);
            if (n < MAX_STR)
            begin
                spelled[n] = last_first;
                n++;
            end
        end
        else
        begin
            push_refusal();
            return;
        end

        if (room)
        begin
            dict_prefix[free_code] = last_code;
            dict_suffix[free_code] = spelled[0];
            dict_len[free_code]    = 7'(prev_n + 1);
            free_code++;
        end
        last_code  = c;
        last_first = spelled[0];

        for (int unsigned k = 0; k < n; k++)
        begin
            b.data = spelled[k];
            b.last = (k + 1 == n);
            b.bad  = 1'b0;
            expected_bytes = {expected_bytes, b};
        end
    endfunction

    // ------------------------------------------------------------------
    // Checker: every output beat is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        decoded_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: output beat with nothing expected: %h %b %b",
                         $time, data_byte, last_byte, bad_code);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (data_byte !== want.data)
                begin
                    mismatch_count++;
                    $display("%0t: data_byte expected %h actual %h", $time, want.data, data_byte);
                end
                if (last_byte !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last_byte expected %b actual %b", $time, want.last, last_byte);
                end
                if (bad_code !== want.bad)
                begin
                    mismatch_count++;
                    $display("%0t: bad_code expected %b actual %b", $time, want.bad, bad_code);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one code on the input channel, idling first at random, and waits
    // until the beat is taken. Valid is left high so that a following beat can
    // go straight out; the drain task lowers it.
    task automatic send_code(input logic [CODE_W-1:0] c, input logic sos);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid        <= 1'b1;
        code            <= c;
        start_of_stream <= sos;
        do
            @(posedge clk);
        while (!in_ready);
        predict_decode(c, sos);
    endtask

    // Stops offering codes and waits until every expected beat has come out.
    task automatic drain_outputs(input int unsigned pad);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (pad) @(posedge clk);
    endtask

    // Picks the next code of a random stream. Most codes are well formed:
    // literals, defined entries and the code about to be made. A few open a
    // new stream, and the rest are noise that is mostly refused.
    task automatic pick_stream_code(output logic [CODE_W-1:0] c, output logic sos);
        int unsigned r;
        r   = $urandom_range(99);
        sos = 1'b0;
        if (r < 6)
        begin
            sos = 1'b1;
            c   = ($urandom_range(9) == 0) ? CODE_W'($urandom_range(4095))
                                           : CODE_W'($urandom_range(255));
        end
        else if (r < 14)
        begin
            c = CODE_W'($urandom_range(4095));
        end
        else if (r < 30 && free_code < DICT_DEPTH)
        begin
            c = CODE_W'(free_code);
        end
        else if (free_code > LITERALS && $urandom_range(1) == 1)
        begin
            c = CODE_W'($urandom_range(free_code - 1, LITERALS));
        end
        else
        begin
            c = CODE_W'($urandom_range(255));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the code field, codes with no stream open, refused opening
    // codes, undefined codes and the code-equals-next-free case.
    task automatic test_directed_codes();
        send_code(12'hFFF, 1'b0);   // no stream yet, so treated as an opening code
        send_code(LITERALS, 1'b1);  // an entry code cannot open a stream
        send_code(12'h000, 1'b0);   // opens the stream with the lowest literal
        send_code(12'h0FF, 1'b0);
        send_code(LITERALS, 1'b0);
        send_code(12'd258, 1'b0);   // equal to the next free code
        send_code(12'hFFF, 1'b0);
        send_code(12'd300, 1'b0);
        send_code(12'h080, 1'b1);   // restart; older entries are gone
        send_code(LITERALS, 1'b0);
        send_code(12'd257, 1'b0);
        send_code(12'h055, 1'b0);
        send_code(12'd258, 1'b0);
        send_code(12'hFFF, 1'b1);   // refused restart keeps the dictionary
        send_code(12'd258, 1'b0);
        send_code(12'h0AA, 1'b1);
        send_code(12'd257, 1'b0);   // above the next free code
        send_code(LITERALS, 1'b0);
        drain_outputs(4);
    endtask

    // Builds ever longer strings of one byte until the length bound stops the
    // dictionary growing, then checks that decoding carries on without it.
    task automatic test_string_length_bound();
        send_code(12'h05A, 1'b1);
        for (int k = 0; k < MAX_STR - 1; k++)
            send_code(CODE_W'(free_code), 1'b0);
        send_code(CODE_W'(free_code), 1'b0);   // no room left, so undefined
        send_code(CODE_W'(free_code - 1), 1'b0);
        send_code(12'h0B5, 1'b0);
        send_code(LITERALS, 1'b0);
        drain_outputs(4);
    endtask

    task automatic test_random_streams(input int unsigned count);
        logic [CODE_W-1:0] c;
        logic sos;
        for (int unsigned k = 0; k < count; k++)
        begin
            pick_stream_code(c, sos);
            send_code(c, sos);
        end
        drain_outputs(4);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 24;
        recv_stall_pct = 68;
        test_directed_codes();
        test_string_length_bound();
        test_random_streams(12);

        send_idle_pct  = 68;
        recv_stall_pct = 24;
        test_random_streams(12);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_streams(12);

        drain_outputs(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guards against a hang anywhere in the run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout with %0d beats still expected", $time, expected_bytes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
